@@ design/uswalk_pkg.sv @@
// uswalk_pkg: shared constants and types for the ustar member stream walker
// used by uswalk_step and ustar_member_stream_walker_unit; no dependencies
package uswalk_pkg;

  localparam int MANIFEST_MAX = 4096;
  localparam int MAN_W = $clog2(MANIFEST_MAX);
  localparam logic [MAN_W-1:0] MAN_LIMIT = MAN_W'(MANIFEST_MAX - 1);

  localparam int SIZE_W = 36;

  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_OTHER    = 3'd1;
  localparam logic [2:0] KIND_MANIFEST = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
  localparam logic [2:0] KIND_PADDING  = 3'd4;
  localparam logic [2:0] KIND_ENDED    = 3'd5;
  localparam logic [2:0] KIND_STOPPED  = 3'd6;

  localparam logic [2:0] EVT_NONE    = 3'd0;
  localparam logic [2:0] EVT_MEMBER  = 3'd1;
  localparam logic [2:0] EVT_EMPTY   = 3'd2;
  localparam logic [2:0] EVT_END     = 3'd3;
  localparam logic [2:0] EVT_INVALID = 3'd4;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [2:0]        byte_kind;
    logic [7:0]        payload_index;
    logic              member_last;
    logic [2:0]        header_event;
    logic [SIZE_W-1:0] member_size;
    logic              truncated;
  } res_t;

endpackage

@@ design/uswalk_step.sv @@
// uswalk_step: walker state registers and the per-item next-state logic
// depends on uswalk_pkg
module uswalk_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        arc_byte,
  input  logic              end_in,
  output uswalk_pkg::res_t  res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DATA,
    PH_PAD,
    PH_ENDED,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    MC_OTHER,
    MC_MANIFEST,
    MC_PAYLOAD
  } mclass_t;

  function automatic logic [7:0] manifest_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = "m";
      4'd1:    c = "a";
      4'd2:    c = "n";
      4'd3:    c = "i";
      4'd4:    c = "f";
      4'd5:    c = "e";
      4'd6:    c = "s";
      4'd7:    c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] files_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = "f";
      3'd1:    c = "i";
      3'd2:    c = "l";
      3'd3:    c = "e";
      3'd4:    c = "s";
      default: c = "/";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = "u";
      3'd1:    c = "s";
      3'd2:    c = "t";
      3'd3:    c = "a";
      default: c = "r";
    endcase
    return c;
  endfunction

  phase_t                          phase, phase_next;
  logic [8:0]                      block_position, block_position_next;
  logic [uswalk_pkg::SIZE_W-1:0]   data_remaining, data_remaining_next;
  logic [8:0]                      pad_remaining, pad_remaining_next;
  logic [uswalk_pkg::SIZE_W-1:0]   size_acc, size_acc_next;
  logic                            size_stopped, size_stopped_next;
  logic [5:0]                      name_flags, name_flags_next;
  logic                            magic_ok, magic_ok_next;
  logic                            is_directory, is_directory_next;
  logic                            block_nonzero, block_nonzero_next;
  logic                            empty_run, empty_run_next;
  mclass_t                         member_class, member_class_next;
  logic [7:0]                      payload_count, payload_count_next;
  logic [uswalk_pkg::MAN_W-1:0]    manifest_bytes, manifest_bytes_next;
  logic                            payload_seen, payload_seen_next;

  logic [8:0]                      pos, pm2, pm257;
  logic                            nonzero_now, strip, is_man, is_files;
  logic [uswalk_pkg::SIZE_W-1:0]   dr_dec;
  logic [8:0]                      pad_dec;
  mclass_t                         cls;

  assign pos   = block_position;
  assign pm2   = pos - 9'd2;
  assign pm257 = pos - 9'd257;

  always_comb begin
    phase_next          = phase;
    block_position_next = block_position;
    data_remaining_next = data_remaining;
    pad_remaining_next  = pad_remaining;
    size_acc_next       = size_acc;
    size_stopped_next   = size_stopped;
    name_flags_next     = name_flags;
    magic_ok_next       = magic_ok;
    is_directory_next   = is_directory;
    block_nonzero_next  = block_nonzero;
    empty_run_next      = empty_run;
    member_class_next   = member_class;
    payload_count_next  = payload_count;
    manifest_bytes_next = manifest_bytes;
    payload_seen_next   = payload_seen;

    nonzero_now = block_nonzero | (arc_byte != 8'h00);
    strip       = name_flags[4];
    is_man      = strip ? name_flags[1] : name_flags[0];
    is_files    = strip ? name_flags[3] : name_flags[2];
    cls         = MC_OTHER;
    dr_dec      = (data_remaining != '0) ? data_remaining - 1'b1 : data_remaining;
    pad_dec     = (pad_remaining != '0) ? pad_remaining - 1'b1 : pad_remaining;

    res.data_byte     = arc_byte;
    res.byte_kind     = uswalk_pkg::KIND_HEADER;
    res.payload_index = 8'd0;
    res.member_last   = 1'b0;
    res.header_event  = uswalk_pkg::EVT_NONE;
    res.member_size   = '0;
    res.truncated     = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        block_nonzero_next = nonzero_now;
        // name candidates
        if (pos <= 9'd8 && arc_byte != manifest_char(pos[3:0]))
          name_flags_next[0] = 1'b0;
        if (pos >= 9'd2 && pos <= 9'd10 && arc_byte != manifest_char(pm2[3:0]))
          name_flags_next[1] = 1'b0;
        if (pos < 9'd6 && arc_byte != files_char(pos[2:0]))
          name_flags_next[2] = 1'b0;
        if (pos >= 9'd2 && pos < 9'd8 && arc_byte != files_char(pm2[2:0]))
          name_flags_next[3] = 1'b0;
        if ((pos == 9'd0 && arc_byte != ".") || (pos == 9'd1 && arc_byte != "/"))
          name_flags_next[4] = 1'b0;
        // octal size field
        if (pos >= 9'd124 && pos < 9'd136 && !size_stopped) begin
          if (arc_byte == 8'h00)
            size_stopped_next = 1'b1;
          else if (arc_byte >= "0" && arc_byte <= "7")
            size_acc_next = {size_acc[uswalk_pkg::SIZE_W-4:0], arc_byte[2:0]};
        end
        if (pos == 9'd156)
          is_directory_next = (arc_byte == "5");
        if (pos >= 9'd257 && pos < 9'd262 && arc_byte != magic_char(pm257[2:0]))
          magic_ok_next = 1'b0;
        if ((pos == 9'd263 || pos == 9'd264) && arc_byte != "0")
          magic_ok_next = 1'b0;

        if (pos != 9'd511) begin
          block_position_next = pos + 9'd1;
        end else begin
          if (!nonzero_now) begin
            if (empty_run) begin
              res.header_event = uswalk_pkg::EVT_END;
              phase_next       = PH_ENDED;
            end else begin
              res.header_event = uswalk_pkg::EVT_EMPTY;
              empty_run_next   = 1'b1;
            end
          end else if (!magic_ok) begin
            empty_run_next   = 1'b0;
            res.header_event = uswalk_pkg::EVT_INVALID;
            phase_next       = PH_STOPPED;
          end else begin
            empty_run_next   = 1'b0;
            res.header_event = uswalk_pkg::EVT_MEMBER;
            res.member_size  = size_acc;
            if (is_man && !is_directory)
              cls = MC_MANIFEST;
            else if (is_files && !is_directory)
              cls = MC_PAYLOAD;
            else
              cls = MC_OTHER;
            member_class_next = cls;
            if (cls == MC_PAYLOAD) begin
              if (payload_seen) begin
                if (payload_count != 8'd255)
                  payload_count_next = payload_count + 8'd1;
              end else begin
                payload_seen_next = 1'b1;
              end
              res.payload_index = payload_count_next;
            end
            manifest_bytes_next = '0;
            data_remaining_next = size_acc;
            pad_remaining_next  = 9'd0 - size_acc[8:0];
            phase_next          = (size_acc != '0) ? PH_DATA : PH_HEADER;
          end
          // start a fresh header
          block_position_next = 9'd0;
          size_acc_next       = '0;
          size_stopped_next   = 1'b0;
          name_flags_next     = 6'h3f;
          magic_ok_next       = 1'b1;
          is_directory_next   = 1'b0;
          block_nonzero_next  = 1'b0;
        end
      end
      PH_DATA: begin
        if (member_class == MC_PAYLOAD) begin
          res.byte_kind     = uswalk_pkg::KIND_PAYLOAD;
          res.payload_index = payload_count;
        end else if (member_class == MC_MANIFEST && manifest_bytes < uswalk_pkg::MAN_LIMIT) begin
          res.byte_kind       = uswalk_pkg::KIND_MANIFEST;
          manifest_bytes_next = manifest_bytes + 1'b1;
        end else begin
          res.byte_kind = uswalk_pkg::KIND_OTHER;
        end
        data_remaining_next = dr_dec;
        if (dr_dec == '0) begin
          res.member_last = 1'b1;
          phase_next      = (pad_remaining != '0) ? PH_PAD : PH_HEADER;
        end
      end
      PH_PAD: begin
        res.byte_kind      = uswalk_pkg::KIND_PADDING;
        pad_remaining_next = pad_dec;
        if (pad_dec == '0)
          phase_next = PH_HEADER;
      end
      PH_ENDED: begin
        res.byte_kind = uswalk_pkg::KIND_ENDED;
      end
      default: begin
        res.byte_kind = uswalk_pkg::KIND_STOPPED;
      end
    endcase

    res.truncated = end_in && (phase_next == PH_DATA);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_in)) begin
      phase          <= PH_HEADER;
      block_position <= 9'd0;
      data_remaining <= '0;
      pad_remaining  <= 9'd0;
      size_acc       <= '0;
      size_stopped   <= 1'b0;
      name_flags     <= 6'h3f;
      magic_ok       <= 1'b1;
      is_directory   <= 1'b0;
      block_nonzero  <= 1'b0;
      empty_run      <= 1'b0;
      member_class   <= MC_OTHER;
      payload_count  <= 8'd0;
      manifest_bytes <= '0;
      payload_seen   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      block_position <= block_position_next;
      data_remaining <= data_remaining_next;
      pad_remaining  <= pad_remaining_next;
      size_acc       <= size_acc_next;
      size_stopped   <= size_stopped_next;
      name_flags     <= name_flags_next;
      magic_ok       <= magic_ok_next;
      is_directory   <= is_directory_next;
      block_nonzero  <= block_nonzero_next;
      empty_run      <= empty_run_next;
      member_class   <= member_class_next;
      payload_count  <= payload_count_next;
      manifest_bytes <= manifest_bytes_next;
      payload_seen   <= payload_seen_next;
    end
  end

endmodule

@@ design/ustar_member_stream_walker_unit.sv @@
// ustar_member_stream_walker_unit: top level with input and result registers
// depends on uswalk_pkg and uswalk_step
//
// usage
//   archive bytes enter on archive_valid/archive_ready with stream_end set on
//   the last byte of a buffer; each byte gives exactly one result item on
//   result_valid/result_ready carrying the byte, its kind, payload index,
//   member_last, header_event, member_size and truncated
//   an accepted item waits in the input register until the result register is
//   free or being taken, then the walker state advances and the result is loaded
//   into the result register, where it is offered on result_valid
//   throughput is one item per cycle while result_ready is high; the single
//   step of walker state between the input and result registers sets that figure
//   when result_ready is low the result register holds, the input register
//   still takes one more item, and archive_ready then drops until the
//   result is taken
//   rst (synchronous, active high) empties both registers and returns the
//   walker to the start of an archive; a stream_end item does the same for
//   the items after it
module ustar_member_stream_walker_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    archive_byte,
  input  logic                          stream_end,
  input  logic                          archive_valid,
  output logic                          archive_ready,
  output logic [7:0]                    data_byte,
  output logic [2:0]                    byte_kind,
  output logic [7:0]                    payload_index,
  output logic                          member_last,
  output logic [2:0]                    header_event,
  output logic [uswalk_pkg::SIZE_W-1:0] member_size,
  output logic                          truncated,
  output logic                          result_valid,
  input  logic                          result_ready
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic             in_end;
  logic             out_full;
  uswalk_pkg::res_t res_comb, res_q;
  logic             move;

  assign move          = in_full && (!out_full || result_ready);
  assign archive_ready = !in_full || move;

  uswalk_step u_step (
    .clk      (clk),
    .rst      (rst),
    .step     (move),
    .arc_byte (in_byte),
    .end_in   (in_end),
    .res      (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      in_full  <= (archive_valid && archive_ready) || (in_full && !move);
      out_full <= move || (out_full && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (archive_valid && archive_ready) begin
      in_byte <= archive_byte;
      in_end  <= stream_end;
    end
    if (move)
      res_q <= res_comb;
  end

  assign result_valid  = out_full;
  assign data_byte     = res_q.data_byte;
  assign byte_kind     = res_q.byte_kind;
  assign payload_index = res_q.payload_index;
  assign member_last   = res_q.member_last;
  assign header_event  = res_q.header_event;
  assign member_size   = res_q.member_size;
  assign truncated     = res_q.truncated;

endmodule

@@ tb/ustar_member_stream_walker_unit_tb.sv @@
// ustar_member_stream_walker_unit_tb: self-checking bench for the ustar member walker
// builds archives byte by byte, predicts every result item and checks them in order
// depends on uswalk_pkg and ustar_member_stream_walker_unit
`timescale 1ns / 100ps

module ustar_member_stream_walker_unit_tb;

  typedef enum logic [2:0] {
    WALK_HEADER, WALK_DATA, WALK_PAD, WALK_ENDED, WALK_STOPPED
  } walk_phase_t;
  typedef enum logic [1:0] {MEMBER_OTHER, MEMBER_MANIFEST, MEMBER_PAYLOAD} member_class_t;
  typedef enum int {HDR_GOOD, HDR_BAD_MAGIC, HDR_BAD_VERSION} hdr_form_t;

  typedef struct packed {
    logic [7:0] value;
    logic       fin;
    logic       hold;
    logic       calm;
  } arch_item_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic [7:0]                    archive_byte = 8'h00;
  logic                          stream_end = 1'b0;
  logic                          archive_valid = 1'b0;
  logic                          archive_ready;
  logic [7:0]                    data_byte;
  logic [2:0]                    byte_kind;
  logic [7:0]                    payload_index;
  logic                          member_last;
  logic [2:0]                    header_event;
  logic [uswalk_pkg::SIZE_W-1:0] member_size;
  logic                          truncated;
  logic                          result_valid;
  logic                          result_ready = 1'b0;

  ustar_member_stream_walker_unit u_dut (
    .clk(clk),
    .rst(rst),
    .archive_byte(archive_byte),
    .stream_end(stream_end),
    .archive_valid(archive_valid),
    .archive_ready(archive_ready),
    .data_byte(data_byte),
    .byte_kind(byte_kind),
    .payload_index(payload_index),
    .member_last(member_last),
    .header_event(header_event),
    .member_size(member_size),
    .truncated(truncated),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  always #10 clk = ~clk;

  // walker state as predicted
  walk_phase_t      walk_phase;
  int unsigned      hdr_pos;
  logic [35:0]      data_left;
  logic [8:0]       pad_left;
  logic [35:0]      size_acc;
  bit               size_done;
  logic [5:0]       name_flags;
  bit               magic_good;
  bit               dir_flag;
  bit               hdr_nonzero;
  bit               empty_seen;
  member_class_t    cur_class;
  logic [7:0]       payload_no;
  bit               payload_started;
  int unsigned      manifest_count;

  arch_item_t       stim_q[$];
  uswalk_pkg::res_t expected_q[$];
  logic [7:0]       arch_q[$];
  arch_item_t       next_item;
  bit               byte_taken = 1'b0;
  bit               calm_now = 1'b0;
  int unsigned      mismatch_count = 0;
  int unsigned      results_seen = 0;
  int unsigned      random_total = 0;

  function automatic logic [7:0] man_char(input int unsigned i);
    logic [63:0] w;
    w = "manifest";
    return (i < 8) ? w[8*(7-i) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] files_char(input int unsigned i);
    logic [47:0] w;
    w = "files/";
    return w[8*(5-i) +: 8];
  endfunction

  function automatic logic [7:0] magic_char(input int unsigned i);
    logic [39:0] w;
    w = "ustar";
    return w[8*(4-i) +: 8];
  endfunction

  function automatic void clear_header_state();
    hdr_pos = 0;
    size_acc = '0;
    size_done = 1'b0;
    name_flags = 6'h3f;
    magic_good = 1'b1;
    dir_flag = 1'b0;
    hdr_nonzero = 1'b0;
  endfunction

  function automatic void walk_reset();
    walk_phase = WALK_HEADER;
    data_left = '0;
    pad_left = '0;
    empty_seen = 1'b0;
    cur_class = MEMBER_OTHER;
    payload_no = 8'h00;
    payload_started = 1'b0;
    manifest_count = 0;
    clear_header_state();
  endfunction

  function automatic uswalk_pkg::res_t walk_byte(input logic [7:0] b, input logic fin);
    uswalk_pkg::res_t r;
    int unsigned      pos;
    logic             strip, is_man, is_files;
    r = '0;
    r.data_byte = b;
    case (walk_phase)
      WALK_HEADER: begin
        pos = hdr_pos;
        r.byte_kind = uswalk_pkg::KIND_HEADER;
        if (b != 8'h00) hdr_nonzero = 1'b1;
        if (pos <= 8 && b != man_char(pos)) name_flags[0] = 1'b0;
        if (pos >= 2 && pos <= 10 && b != man_char(pos - 2)) name_flags[1] = 1'b0;
        if (pos < 6 && b != files_char(pos)) name_flags[2] = 1'b0;
        if (pos >= 2 && pos < 8 && b != files_char(pos - 2)) name_flags[3] = 1'b0;
        if (pos == 0 && b != ".") name_flags[4] = 1'b0;
        if (pos == 1 && b != "/") name_flags[4] = 1'b0;
        if (pos >= 124 && pos < 136 && !size_done) begin
          if (b == 8'h00) size_done = 1'b1;
          else if (b >= "0" && b <= "7") size_acc = {size_acc[32:0], b[2:0]};
        end
        if (pos == 156) dir_flag = (b == "5");
        if (pos >= 257 && pos < 262 && b != magic_char(pos - 257)) magic_good = 1'b0;
        if ((pos == 263 || pos == 264) && b != "0") magic_good = 1'b0;
        if (pos < 511) begin
          hdr_pos = pos + 1;
        end else begin
          if (!hdr_nonzero) begin
            if (empty_seen) begin
              r.header_event = uswalk_pkg::EVT_END;
              walk_phase = WALK_ENDED;
            end else begin
              r.header_event = uswalk_pkg::EVT_EMPTY;
              empty_seen = 1'b1;
            end
          end else if (!magic_good) begin
            empty_seen = 1'b0;
            r.header_event = uswalk_pkg::EVT_INVALID;
            walk_phase = WALK_STOPPED;
          end else begin
            strip = name_flags[4];
            is_man = strip ? name_flags[1] : name_flags[0];
            is_files = strip ? name_flags[3] : name_flags[2];
            empty_seen = 1'b0;
            r.header_event = uswalk_pkg::EVT_MEMBER;
            r.member_size = size_acc;
            if (is_man && !dir_flag) cur_class = MEMBER_MANIFEST;
            else if (is_files && !dir_flag) cur_class = MEMBER_PAYLOAD;
            else cur_class = MEMBER_OTHER;
            if (cur_class == MEMBER_PAYLOAD) begin
              if (payload_started) begin
                if (payload_no != 8'hff) payload_no++;
              end else begin
                payload_started = 1'b1;
              end
              r.payload_index = payload_no;
            end
            manifest_count = 0;
            data_left = size_acc;
            pad_left = 9'd0 - size_acc[8:0];
            walk_phase = (size_acc != 0) ? WALK_DATA : WALK_HEADER;
          end
          clear_header_state();
        end
      end
      WALK_DATA: begin
        if (cur_class == MEMBER_PAYLOAD) begin
          r.byte_kind = uswalk_pkg::KIND_PAYLOAD;
          r.payload_index = payload_no;
        end else if (cur_class == MEMBER_MANIFEST &&
                     manifest_count < uswalk_pkg::MANIFEST_MAX - 1) begin
          r.byte_kind = uswalk_pkg::KIND_MANIFEST;
          manifest_count++;
        end else begin
          r.byte_kind = uswalk_pkg::KIND_OTHER;
        end
        if (data_left != 0) data_left--;
        if (data_left == 0) begin
          r.member_last = 1'b1;
          walk_phase = (pad_left != 0) ? WALK_PAD : WALK_HEADER;
        end
      end
      WALK_PAD: begin
        r.byte_kind = uswalk_pkg::KIND_PADDING;
        if (pad_left != 0) pad_left--;
        if (pad_left == 0) walk_phase = WALK_HEADER;
      end
      WALK_ENDED: r.byte_kind = uswalk_pkg::KIND_ENDED;
      default: r.byte_kind = uswalk_pkg::KIND_STOPPED;
    endcase
    if (fin && walk_phase == WALK_DATA) r.truncated = 1'b1;
    if (fin) walk_reset();
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string label, input logic [35:0] got,
                             input logic [35:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", results_seen, label, got, want));
  endtask

  // result side and acceptance of input items
  always @(posedge clk) begin
    uswalk_pkg::res_t want;
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = archive_valid && archive_ready;
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("result %0d with no item outstanding", results_seen));
        end else begin
          want = expected_q.pop_front();
          check_field("data_byte", data_byte, want.data_byte);
          check_field("byte_kind", byte_kind, want.byte_kind);
          check_field("payload_index", payload_index, want.payload_index);
          check_field("member_last", member_last, want.member_last);
          check_field("header_event", header_event, want.header_event);
          check_field("member_size", member_size, want.member_size);
          check_field("truncated", truncated, want.truncated);
        end
        results_seen++;
      end
      if (byte_taken) expected_q.push_back(walk_byte(archive_byte, stream_end));
    end
  end

  // archive side driver
  always @(negedge clk) begin
    if (rst) begin
      archive_valid <= 1'b0;
    end else if (!archive_valid || byte_taken) begin
      if (stim_q.size() != 0 && !(stim_q[0].hold && expected_q.size() != 0) &&
          (stim_q[0].calm || $urandom_range(0, 99) >= 32)) begin
        next_item = stim_q.pop_front();
        calm_now = next_item.calm;
        archive_byte <= next_item.value;
        stream_end <= next_item.fin;
        archive_valid <= 1'b1;
      end else begin
        archive_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_ready <= calm_now || ($urandom_range(0, 99) >= 32);
  end

  function automatic logic [7:0] size_noise();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c >= "0" && c <= "7");
    return c;
  endfunction

  task automatic add_header(input string name, input logic [35:0] len, input logic [7:0] tflag,
                            input hdr_form_t form, input bit noisy);
    logic [7:0]  h [0:511];
    logic [2:0]  dg [0:11];
    logic [35:0] v;
    int          nd, slot, i, noise;
    for (i = 0; i < 512; i++) h[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    for (i = 0; i < name.len(); i++) h[i] = name[i];
    h[name.len()] = 8'h00;
    nd = 0;
    v = len;
    do begin
      dg[nd] = v[2:0];
      v = v >> 3;
      nd++;
    end while (v != 0);
    slot = 124;
    if (!noisy) begin
      for (i = (nd > 11) ? 11 : 10; i >= 0; i--) begin
        h[slot] = 8'h30 + ((i < nd) ? 8'(dg[i]) : 8'h00);
        slot++;
      end
    end else begin
      noise = $urandom_range(0, 12 - nd);
      i = nd - 1;
      while (i >= 0 || noise > 0) begin
        if (noise > 0 && (i < 0 || $urandom_range(0, 1) == 1)) begin
          h[slot] = size_noise();
          noise--;
        end else begin
          h[slot] = 8'h30 + 8'(dg[i]);
          i--;
        end
        slot++;
      end
    end
    if (slot < 136) h[slot] = 8'h00;
    h[156] = tflag;
    for (i = 0; i < 5; i++) h[257 + i] = magic_char(i);
    h[263] = "0";
    h[264] = "0";
    if (form == HDR_BAD_MAGIC) begin
      i = 257 + $urandom_range(0, 4);
      h[i] = h[i] ^ 8'($urandom_range(1, 255));
    end else if (form == HDR_BAD_VERSION) begin
      h[263 + $urandom_range(0, 1)] = 8'h30 ^ 8'($urandom_range(1, 255));
    end
    for (i = 0; i < 512; i++) arch_q.push_back(h[i]);
  endtask

  task automatic add_data(input int unsigned len);
    repeat (len) arch_q.push_back(8'($urandom));
    repeat ((512 - len % 512) % 512) arch_q.push_back(8'($urandom));
  endtask

  task automatic ship_archive(input int unsigned cut, input bit hold, input bit calm);
    int unsigned k;
    for (k = 0; k <= cut; k++) stim_q.push_back({arch_q[k], k == cut, hold && k == 0, calm});
    arch_q.delete();
  endtask

  task automatic random_stream();
    int unsigned n;
    n = $urandom_range(1, 48);
    repeat (n) arch_q.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
    random_total += n;
    ship_archive(n - 1, 1'b0, 1'b0);
  endtask

  initial begin
    walk_reset();

    // lone bytes, each a stream of its own
    arch_q.push_back(8'hff);
    ship_archive(0, 1'b0, 1'b0);
    arch_q.push_back(8'h00);
    ship_archive(0, 1'b0, 1'b0);

    // payload member with a stripped name, stream ends inside the padding, sent without gaps
    add_header("./files/a.bin", 3, "0", HDR_GOOD, 1'b1);
    add_data(3);
    ship_archive(511 + 3 + 8, 1'b1, 1'b1);

    // broken version, then bytes after the stop
    add_header("manifest", 0, "0", HDR_BAD_VERSION, 1'b0);
    repeat (6) arch_q.push_back(8'($urandom));
    ship_archive(arch_q.size() - 1, 1'b1, 1'b0);

    // short streams that end inside a header
    while (random_total < 360) random_stream();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || archive_valid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ustar_member_stream_walker_unit_tb: done, clean");
    end else begin
      $display("ustar_member_stream_walker_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ustar_member_stream_walker_unit_tb: done, errors");
    $finish;
  end

endmodule
